// ===== design/wsr_pkg.sv =====
// Shared constants and types for the windowed sample ring statistics block.
package wsr_pkg;

  localparam int MaxLength = 64;
  localparam int AddrW     = $clog2(MaxLength);
  localparam int LenW      = AddrW + 1;
  localparam int SampleW   = 16;
  localparam int StepW     = SampleW + 1;
  localparam int SumW      = SampleW + AddrW;
  localparam int CntW      = $clog2(SumW);

  localparam logic [LenW-1:0]    LenReset    = LenW'(10);
  localparam logic [SampleW-1:0] MinusOneQ88 = SampleW'(-256);

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRead   = 1'b1;

  typedef struct packed {
    logic               clear;
    logic               we;
    logic [AddrW-1:0]   waddr;
    logic [SampleW-1:0] wdata;
    logic [AddrW-1:0]   raddr;
  } store_ctl_t;

  typedef struct packed {
    logic                   start;
    logic signed [SumW-1:0] dividend;
    logic [LenW-1:0]        divisor;
  } div_req_t;

endpackage

// ===== design/windowed_sample_ring_stats_unit.sv =====
// Top level of the windowed sample ring statistics block with its sequencer.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_ready_o | command_i, sample_i, slot_index_i
//   out     | output    | out_valid_o/out_ready_i | latest_sample_o .. index_error_o
//   cfg     | input     | cfg_we_i (no wait)      | cfg_wdata_i (window length)
//
// Each request passes through the store reads for the old slot, the latest and the
// previous sample and through the serial mean divider (one quotient bit per cycle
// over the 22-bit sum) before its result is loaded.
// The next request can be accepted in the cycle after the result is loaded.
// Reset and a window length write clear the store through its valid bits.
// A result held in the output register does not stop the next request from being
// accepted; a new result waits only if the previous one is still not taken.
module windowed_sample_ring_stats_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               command_i,
  input  logic signed [wsr_pkg::SampleW-1:0] sample_i,
  input  logic [wsr_pkg::AddrW-1:0]          slot_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [wsr_pkg::SampleW-1:0] latest_sample_o,
  output logic signed [wsr_pkg::StepW-1:0]   last_step_o,
  output logic signed [wsr_pkg::SumW-1:0]    window_sum_o,
  output logic signed [wsr_pkg::SampleW-1:0] window_mean_o,
  output logic signed [wsr_pkg::SampleW-1:0] entry_value_o,
  output logic                               index_error_o,
  input  logic                               cfg_we_i,
  input  logic [wsr_pkg::LenW-1:0]           cfg_wdata_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFetch = 3'd1;
  localparam logic [2:0] StLast  = 3'd2;
  localparam logic [2:0] StPrev  = 3'd3;
  localparam logic [2:0] StCapt  = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic                        cmd_q;
  logic [wsr_pkg::SampleW-1:0] sample_q;
  logic [wsr_pkg::AddrW-1:0]   idx_q;
  logic [wsr_pkg::LenW-1:0]    len_q;
  logic [wsr_pkg::AddrW-1:0]   wp_q, wp_d;
  logic [wsr_pkg::SumW-1:0]    total_q, total_d;
  logic [wsr_pkg::SampleW-1:0] latest_q;
  logic [wsr_pkg::StepW-1:0]   step_q;
  logic [wsr_pkg::SampleW-1:0] entry_q;
  logic                        err_q;
  logic                        out_valid_q, out_valid_d;
  logic [wsr_pkg::SampleW-1:0] o_latest_q;
  logic [wsr_pkg::StepW-1:0]   o_step_q;
  logic [wsr_pkg::SumW-1:0]    o_sum_q;
  logic [wsr_pkg::SampleW-1:0] o_mean_q;
  logic [wsr_pkg::SampleW-1:0] o_entry_q;
  logic                        o_err_q;

  logic [wsr_pkg::LenW-1:0]    len_eff;
  logic [wsr_pkg::AddrW-1:0]   len_m1;
  logic [wsr_pkg::AddrW-1:0]   p1, p2;
  logic [wsr_pkg::LenW-1:0]    wp_inc;
  logic                        idx_err;
  logic                        accept;
  logic                        load_out;
  logic [wsr_pkg::SampleW-1:0] rdata;
  logic [wsr_pkg::SampleW-1:0] div_q;
  logic                        div_done;
  wsr_pkg::store_ctl_t         st_ctl;
  wsr_pkg::div_req_t           div_req;

  // A length of zero counts as one and anything above the ring size as the ring size.
  always_comb begin
    if (len_q == '0) begin
      len_eff = wsr_pkg::LenW'(1);
    end else if (len_q > wsr_pkg::LenW'(wsr_pkg::MaxLength)) begin
      len_eff = wsr_pkg::LenW'(wsr_pkg::MaxLength);
    end else begin
      len_eff = len_q;
    end
  end

  assign len_m1  = wsr_pkg::AddrW'(len_eff - 1'b1);
  assign p1      = (wp_q == '0) ? len_m1 : wp_q - 1'b1;
  assign p2      = (p1 == '0) ? len_m1 : p1 - 1'b1;
  assign wp_inc  = {1'b0, wp_q} + 1'b1;
  assign idx_err = {1'b0, idx_q} >= len_eff;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    st_ctl.clear = cfg_we_i;
    st_ctl.we    = (state_q == StFetch) && (cmd_q == wsr_pkg::CmdInsert);
    st_ctl.waddr = wp_q;
    st_ctl.wdata = sample_q;
    unique case (state_q)
      StIdle:  st_ctl.raddr = (command_i == wsr_pkg::CmdRead) ? slot_index_i : wp_q;
      StLast:  st_ctl.raddr = p1;
      StPrev:  st_ctl.raddr = p2;
      default: st_ctl.raddr = wp_q;
    endcase
  end

  assign div_req.start    = (state_q == StLast);
  assign div_req.dividend = total_q;
  assign div_req.divisor  = len_eff;

  wsr_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (st_ctl),
    .rdata_o (rdata)
  );

  wsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle:  if (accept) state_d = StFetch;
      StFetch: begin
        if (cmd_q == wsr_pkg::CmdInsert) begin
          total_d = total_q + wsr_pkg::SumW'($signed(sample_q))
                            - wsr_pkg::SumW'($signed(rdata));
          wp_d    = (wp_inc == len_eff) ? '0 : wp_inc[wsr_pkg::AddrW-1:0];
        end
        state_d = StLast;
      end
      StLast:  state_d = StPrev;
      StPrev:  state_d = StCapt;
      StCapt:  state_d = StDiv;
      StDiv:   if (div_done) state_d = StDone;
      StDone:  begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (cfg_we_i) begin
      wp_d    = '0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= wsr_pkg::LenReset;
      wp_q        <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= command_i;
      sample_q <= sample_i;
      idx_q    <= slot_index_i;
    end
    if (state_q == StFetch) begin
      if (cmd_q == wsr_pkg::CmdInsert) begin
        entry_q <= '0;
        err_q   <= 1'b0;
      end else begin
        entry_q <= idx_err ? wsr_pkg::MinusOneQ88 : rdata;
        err_q   <= idx_err;
      end
    end
    if (state_q == StPrev) begin
      latest_q <= rdata;
    end
    if (state_q == StCapt) begin
      step_q <= wsr_pkg::StepW'($signed(latest_q)) - wsr_pkg::StepW'($signed(rdata));
    end
    if (load_out) begin
      o_latest_q <= latest_q;
      o_step_q   <= step_q;
      o_sum_q    <= total_q;
      o_mean_q   <= div_q;
      o_entry_q  <= entry_q;
      o_err_q    <= err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign latest_sample_o = o_latest_q;
  assign last_step_o     = o_step_q;
  assign window_sum_o    = o_sum_q;
  assign window_mean_o   = o_mean_q;
  assign entry_value_o   = o_entry_q;
  assign index_error_o   = o_err_q;

endmodule

// ===== design/wsr_store.sv =====
// Sample store: memory with one write port, one registered read port and per-entry valid bits.
module wsr_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wsr_pkg::store_ctl_t         ctl_i,
  output logic [wsr_pkg::SampleW-1:0] rdata_o
);

  logic [wsr_pkg::SampleW-1:0]   mem [wsr_pkg::MaxLength];
  logic [wsr_pkg::SampleW-1:0]   rdata_q;
  logic [wsr_pkg::MaxLength-1:0] valid_q, valid_d;
  logic                          rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[ctl_i.waddr] <= ctl_i.wdata;
    end
    rdata_q <= mem[ctl_i.raddr];
  end

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.clear) begin
      valid_d = '0;
    end else if (ctl_i.we) begin
      valid_d[ctl_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      rvalid_q <= valid_q[ctl_i.raddr] && !ctl_i.clear;
    end
  end

  // Entries never written since reset or the last clear read as zero.
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== design/wsr_div.sv =====
// Serial restoring divider for the window mean, one quotient bit per cycle.
module wsr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wsr_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [wsr_pkg::SampleW-1:0] quotient_o
);

  logic [wsr_pkg::SumW-1:0] dq_q, dq_d;
  logic [wsr_pkg::LenW-2:0] rem_q, rem_d;
  logic [wsr_pkg::LenW-1:0] divisor_q;
  logic [wsr_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic                     neg_q;
  logic [wsr_pkg::LenW-1:0] trial;
  logic [wsr_pkg::LenW-1:0] diff;
  logic                     fits;
  logic [wsr_pkg::SumW-1:0] qsigned;

  assign trial = {rem_q, dq_q[wsr_pkg::SumW-1]};
  assign fits  = trial >= divisor_q;
  assign diff  = trial - divisor_q;

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (req_i.start) begin
      dq_d   = req_i.dividend[wsr_pkg::SumW-1] ? wsr_pkg::SumW'(-req_i.dividend)
                                                : wsr_pkg::SumW'(req_i.dividend);
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      dq_d  = {dq_q[wsr_pkg::SumW-2:0], fits};
      rem_d = fits ? diff[wsr_pkg::LenW-2:0] : trial[wsr_pkg::LenW-2:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == wsr_pkg::CntW'(wsr_pkg::SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      neg_q     <= req_i.dividend[wsr_pkg::SumW-1];
      divisor_q <= req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // The magnitude quotient is negated back for a negative sum (truncation toward zero).
  assign qsigned    = neg_q ? wsr_pkg::SumW'(-dq_q) : dq_q;
  assign quotient_o = qsigned[wsr_pkg::SampleW-1:0];
  assign done_o     = done_q;

endmodule
